// ===== rtl/iradf_pkg.sv =====
// Shared constants and types for the IMU rate and angle frame decoder.
package iradf_pkg;

  localparam int unsigned StoreDepthDefault = 64;
  localparam int unsigned DecimWidth        = 4;
  localparam logic [DecimWidth-1:0] DecimReset = 4'd3;

  localparam int unsigned RateWidth  = 27;
  localparam int unsigned AngleWidth = 24;
  localparam int unsigned TempWidth  = 15;
  localparam int unsigned AxisCount  = 3;

  localparam logic [7:0] HdrSync  = 8'h55;
  localparam logic [7:0] HdrRate  = 8'h52;
  localparam logic [7:0] HdrAngle = 8'h53;

  localparam int unsigned MaxCount = 33;
  localparam int unsigned RatePos  = 11;
  localparam int unsigned AnglePos = 22;
  localparam int unsigned TempPos  = 30;
  localparam int unsigned FrameLo  = RatePos;
  localparam int unsigned FrameHi  = TempPos + 1;

  localparam int unsigned RateGain  = 2000;
  localparam int unsigned AngleGain = 180;
  localparam int unsigned TempOffset = 3625;

  // round(|5*raw| / 17): (m * DivRecip) >> DivShift is exact for m below 2^18
  localparam int unsigned TempMagWidth = 18;
  localparam int unsigned DivShift     = 22;
  localparam int unsigned DivRecip     = 246724;
  localparam int unsigned TempQWidth   = 14;
  localparam int unsigned TempRound    = 8;

  typedef enum logic {
    ModeByte = 1'b0,
    ModeIdle = 1'b1
  } mode_e;

  typedef enum logic {
    StatusOk  = 1'b0,
    StatusErr = 1'b1
  } status_e;

  typedef struct packed {
    logic                          err;
    logic [AxisCount-1:0][15:0]    rate;
    logic [AxisCount-1:0][15:0]    angle;
    logic [15:0]                   temp;
  } frame_t;

  typedef struct packed {
    logic push;
  } fifo_ctl_t;

endpackage

// ===== rtl/iradf_front.sv =====
// Front end: byte capture, write position, idle-event decimation and frame snapshot.
module iradf_front
  import iradf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = StoreDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  mode_i,
  input  logic [7:0]            data_byte_i,
  input  logic [DecimWidth-1:0] decim_i,
  input  logic                  fifo_full_i,
  output logic                  push_o,
  output frame_t                frame_o
);

  localparam int unsigned PosWidth = $clog2(STORE_DEPTH);

  logic [PosWidth-1:0]   pos_q, pos_d;
  logic [DecimWidth-1:0] idle_cnt_q, idle_cnt_d, idle_inc;
  logic [7:0]            bytes_q [FrameLo:FrameHi];
  logic                  beat, is_idle, parse, hdr_ok, len_ok;

  assign in_ready_o = !fifo_full_i;
  assign beat       = in_valid_i && in_ready_o;
  assign is_idle    = (mode_e'(mode_i) == ModeIdle);
  assign idle_inc   = idle_cnt_q + 1'b1;
  assign parse      = beat && is_idle && (idle_inc >= decim_i);

  always_comb begin
    pos_d      = pos_q;
    idle_cnt_d = idle_cnt_q;
    if (beat) begin
      if (is_idle) begin
        pos_d      = '0;
        idle_cnt_d = parse ? '0 : idle_inc;
      end else if (pos_q == PosWidth'(STORE_DEPTH - 1)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      idle_cnt_q <= '0;
      for (int k = FrameLo; k <= FrameHi; k++) begin
        bytes_q[k] <= '0;
      end
    end else begin
      pos_q      <= pos_d;
      idle_cnt_q <= idle_cnt_d;
      for (int k = FrameLo; k <= FrameHi; k++) begin
        if (beat && !is_idle && pos_q == PosWidth'(k)) begin
          bytes_q[k] <= data_byte_i;
        end
      end
    end
  end

  assign len_ok = (pos_q <= PosWidth'(MaxCount));
  assign hdr_ok = (bytes_q[RatePos] == HdrSync) && (bytes_q[RatePos+1] == HdrRate)
               && (bytes_q[AnglePos] == HdrSync) && (bytes_q[AnglePos+1] == HdrAngle);

  always_comb begin
    frame_o.err = !(len_ok && hdr_ok);
    for (int a = 0; a < AxisCount; a++) begin
      frame_o.rate[a]  = {bytes_q[RatePos + 3 + 2*a], bytes_q[RatePos + 2 + 2*a]};
      frame_o.angle[a] = {bytes_q[AnglePos + 3 + 2*a], bytes_q[AnglePos + 2 + 2*a]};
    end
    frame_o.temp = {bytes_q[TempPos + 1], bytes_q[TempPos]};
  end

  assign push_o = parse;

endmodule

// ===== rtl/iradf_fifo.sv =====
// Two-entry frame queue between front end and back end.
module iradf_fifo
  import iradf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fifo_ctl_t ctl_i,
  input  frame_t    wr_frame_i,
  output logic      full_o,
  output logic      rd_valid_o,
  input  logic      rd_ready_i,
  output frame_t    rd_frame_o
);

  localparam int unsigned Depth = 2;

  frame_t      mem_q [Depth];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        wr_en, rd_en;

  assign full_o     = (cnt_q == 2'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr_en      = ctl_i.push && !full_o;
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign rd_frame_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) wr_ptr_q <= !wr_ptr_q;
      if (rd_en) rd_ptr_q <= !rd_ptr_q;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> !full_o) else $error("push into full queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(Depth)) else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == 2'(Depth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

// ===== rtl/iradf_back.sv =====
// Back end: two-stage scaling pipeline, stage A followed by the output register.
module iradf_back
  import iradf_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  frame_t                       frame_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         status_o,
  output logic signed [RateWidth-1:0]  roll_rate_o,
  output logic signed [RateWidth-1:0]  pitch_rate_o,
  output logic signed [RateWidth-1:0]  yaw_rate_o,
  output logic signed [AngleWidth-1:0] roll_angle_o,
  output logic signed [AngleWidth-1:0] pitch_angle_o,
  output logic signed [AngleWidth-1:0] yaw_angle_o,
  output logic signed [TempWidth-1:0]  temperature_centi_o
);

  localparam int unsigned ProdWidth = TempMagWidth + TempMagWidth;

  // stage A
  logic                                      a_valid_q, a_ready, a_err_q, a_neg_q;
  logic signed [AxisCount-1:0][RateWidth-1:0]  a_rate_q;
  logic signed [AxisCount-1:0][AngleWidth-1:0] a_angle_q;
  logic [TempMagWidth-1:0]                   a_mag_q;
  logic signed [18:0]                        t_n;
  logic [18:0]                               t_abs;

  // stage B / output
  logic                         b_ready;
  logic [ProdWidth-1:0]         b_prod;
  logic [TempQWidth-1:0]        b_q;
  logic signed [TempWidth-1:0]  b_temp;

  assign b_ready    = !out_valid_o || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  assign t_n   = (19'(signed'(frame_i.temp)) <<< 2) + 19'(signed'(frame_i.temp));
  assign t_abs = t_n[18] ? 19'(-t_n) : 19'(t_n);

  assign b_prod = ProdWidth'(a_mag_q) * ProdWidth'(DivRecip);
  assign b_q    = b_prod[DivShift +: TempQWidth];
  assign b_temp = (a_neg_q ? -TempWidth'(b_q) : TempWidth'(b_q)) + TempWidth'(TempOffset);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) begin
      a_err_q <= frame_i.err;
      a_neg_q <= t_n[18];
      a_mag_q <= TempMagWidth'(t_abs) + TempMagWidth'(TempRound);
      for (int a = 0; a < AxisCount; a++) begin
        a_rate_q[a]  <= RateWidth'(signed'(frame_i.rate[a])) * RateWidth'(RateGain);
        a_angle_q[a] <= AngleWidth'(signed'(frame_i.angle[a])) * AngleWidth'(AngleGain);
      end
    end
    if (a_valid_q && b_ready) begin
      status_o            <= a_err_q ? StatusErr : StatusOk;
      roll_rate_o         <= a_err_q ? '0 : a_rate_q[0];
      pitch_rate_o        <= a_err_q ? '0 : a_rate_q[1];
      yaw_rate_o          <= a_err_q ? '0 : a_rate_q[2];
      roll_angle_o        <= a_err_q ? '0 : a_angle_q[0];
      pitch_angle_o       <= a_err_q ? '0 : a_angle_q[1];
      yaw_angle_o         <= a_err_q ? '0 : a_angle_q[2];
      temperature_centi_o <= a_err_q ? '0 : b_temp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (a_ready)  a_valid_q   <= in_valid_i;
      if (b_ready)  out_valid_o <= a_valid_q;
    end
  end

endmodule

// ===== rtl/imu_rate_angle_frame_decoder_unit.sv =====
// Top level of the IMU rate and angle frame decoder.
// Takes one beat per clock: a received byte or an idle-line event. Bytes are
// tracked by write position; every Nth idle event (N = decimation register,
// 0 acts as 1) snapshots the frame and hands it through a two-entry queue to
// a two-stage scaling pipeline (stage A, then the output register). The input
// stalls only while both queue entries are held, i.e. when results back up
// behind a stalled output; with a free output the block sustains one beat per
// cycle. The decimation register accepts a write every cycle and must only be
// changed while no frame is in flight.
module imu_rate_angle_frame_decoder_unit
  import iradf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = StoreDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [DecimWidth-1:0]        cfg_decimation_count_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [7:0]                   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         status_o,
  output logic signed [RateWidth-1:0]  roll_rate_o,
  output logic signed [RateWidth-1:0]  pitch_rate_o,
  output logic signed [RateWidth-1:0]  yaw_rate_o,
  output logic signed [AngleWidth-1:0] roll_angle_o,
  output logic signed [AngleWidth-1:0] pitch_angle_o,
  output logic signed [AngleWidth-1:0] yaw_angle_o,
  output logic signed [TempWidth-1:0]  temperature_centi_o
);

  logic [DecimWidth-1:0] decim_q;
  fifo_ctl_t             fifo_ctl;
  frame_t                wr_frame, rd_frame;
  logic                  push, full, rd_valid, rd_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_q <= DecimReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      decim_q <= cfg_decimation_count_i;
    end
  end

  iradf_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .decim_i     (decim_q),
    .fifo_full_i (full),
    .push_o      (push),
    .frame_o     (wr_frame)
  );

  assign fifo_ctl.push = push;

  iradf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (fifo_ctl),
    .wr_frame_i (wr_frame),
    .full_o     (full),
    .rd_valid_o (rd_valid),
    .rd_ready_i (rd_ready),
    .rd_frame_o (rd_frame)
  );

  iradf_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (rd_valid),
    .in_ready_o          (rd_ready),
    .frame_i             (rd_frame),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .roll_rate_o         (roll_rate_o),
    .pitch_rate_o        (pitch_rate_o),
    .yaw_rate_o          (yaw_rate_o),
    .roll_angle_o        (roll_angle_o),
    .pitch_angle_o       (pitch_angle_o),
    .yaw_angle_o         (yaw_angle_o),
    .temperature_centi_o (temperature_centi_o)
  );

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (roll_rate_o == '0 && yaw_angle_o == '0
      && temperature_centi_o == '0)) else $error("error beat carries data");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(temperature_centi_o)))
    else $error("stalled result changed");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> full) else $error("input stalled with queue space");

endmodule

// ===== test/imu_rate_angle_frame_decoder_checker.sv =====
// Checker for the IMU frame decoder: mirrors the byte store, predicts each frame, compares results.
module imu_rate_angle_frame_decoder_checker
  import iradf_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [DecimWidth-1:0]        cfg_decimation_count_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         mode_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         status_i,
  input  logic signed [RateWidth-1:0]  roll_rate_i,
  input  logic signed [RateWidth-1:0]  pitch_rate_i,
  input  logic signed [RateWidth-1:0]  yaw_rate_i,
  input  logic signed [AngleWidth-1:0] roll_angle_i,
  input  logic signed [AngleWidth-1:0] pitch_angle_i,
  input  logic signed [AngleWidth-1:0] yaw_angle_i,
  input  logic signed [TempWidth-1:0]  temperature_centi_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e                                 status;
    logic [AxisCount-1:0][RateWidth-1:0]  rate;
    logic [AxisCount-1:0][AngleWidth-1:0] angle;
    logic [TempWidth-1:0]                 temp;
  } imu_sample_t;

  logic [7:0]            byte_store [StoreDepthDefault];
  int unsigned           wr_pos;
  logic [DecimWidth-1:0] idle_cnt;
  logic [DecimWidth-1:0] decim;
  imu_sample_t           samples_due [$];
  imu_sample_t           want;
  imu_sample_t           got;
  int unsigned           frame_len;
  int unsigned           fails = 0;
  string                 rate_names [AxisCount] = '{"roll_rate", "pitch_rate", "yaw_rate"};
  string                 angle_names [AxisCount] = '{"roll_angle", "pitch_angle", "yaw_angle"};

  assign fail_count_o = fails;

  function automatic logic signed [15:0] stored_word(input int unsigned pos);
    return {byte_store[pos + 1], byte_store[pos]};
  endfunction

  function automatic imu_sample_t decode_frame(input int unsigned len);
    imu_sample_t s;
    logic signed [15:0] w;
    int n;
    int q;
    s = '0;
    if (len > MaxCount || byte_store[RatePos] != HdrSync || byte_store[RatePos + 1] != HdrRate ||
        byte_store[AnglePos] != HdrSync || byte_store[AnglePos + 1] != HdrAngle) begin
      s.status = StatusErr;
      return s;
    end
    s.status = StatusOk;
    for (int a = 0; a < AxisCount; a++) begin
      w = stored_word(RatePos + 2 + 2 * a);
      s.rate[a] = RateWidth'(longint'(w) * longint'(RateGain));
      w = stored_word(AnglePos + 2 + 2 * a);
      s.angle[a] = AngleWidth'(longint'(w) * longint'(AngleGain));
    end
    w = stored_word(TempPos);
    n = int'(w) * 5;
    q = (n >= 0) ? (n + 8) / 17 : -((-n + 8) / 17);
    s.temp = TempWidth'(q + int'(TempOffset));
    return s;
  endfunction

  task automatic check_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      fails++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (byte_store[i]) byte_store[i] = '0;
      wr_pos    = 0;
      idle_cnt  = '0;
      decim     = DecimReset;
      samples_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        decim = cfg_decimation_count_i;
      end
      if (in_valid_i && in_ready_i) begin
        if (mode_i == ModeByte) begin
          byte_store[wr_pos] = data_byte_i;
          wr_pos = (wr_pos + 1) % StoreDepthDefault;
        end else begin
          frame_len = wr_pos;
          wr_pos    = 0;
          idle_cnt  = idle_cnt + 1'b1;
          if (idle_cnt >= decim) begin
            idle_cnt = '0;
            samples_due.push_back(decode_frame(frame_len));
          end
        end
      end
      if (out_valid_i && out_ready_i) begin
        got.status   = status_e'(status_i);
        got.rate[0]  = roll_rate_i;
        got.rate[1]  = pitch_rate_i;
        got.rate[2]  = yaw_rate_i;
        got.angle[0] = roll_angle_i;
        got.angle[1] = pitch_angle_i;
        got.angle[2] = yaw_angle_i;
        got.temp     = temperature_centi_i;
        if (samples_due.size() == 0) begin
          fails++;
          $display("%0t: result beat expected none, got status %0d", $time, status_i);
        end else begin
          want = samples_due.pop_front();
          check_field("status", longint'(want.status), longint'(got.status));
          for (int a = 0; a < AxisCount; a++) begin
            check_field(rate_names[a], longint'($signed(want.rate[a])),
                        longint'($signed(got.rate[a])));
            check_field(angle_names[a], longint'($signed(want.angle[a])),
                        longint'($signed(got.angle[a])));
          end
          check_field("temperature_centi", longint'($signed(want.temp)),
                      longint'($signed(got.temp)));
        end
      end
      pending_o <= samples_due.size();
    end
  end

endmodule

// ===== test/imu_rate_angle_frame_decoder_unit_tb.sv =====
// Testbench top for the IMU frame decoder: clock, reset, byte and frame stimulus, verdict.
module imu_rate_angle_frame_decoder_unit_tb;
  import iradf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HdrIntact  = 4;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [DecimWidth-1:0]        cfg_decimation_count_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic                         mode_i = 1'b0;
  logic [7:0]                   data_byte_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic                         status_o;
  logic signed [RateWidth-1:0]  roll_rate_o;
  logic signed [RateWidth-1:0]  pitch_rate_o;
  logic signed [RateWidth-1:0]  yaw_rate_o;
  logic signed [AngleWidth-1:0] roll_angle_o;
  logic signed [AngleWidth-1:0] pitch_angle_o;
  logic signed [AngleWidth-1:0] yaw_angle_o;
  logic signed [TempWidth-1:0]  temperature_centi_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned beats_sent = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;
  logic [15:0] frame_words [7];

  imu_rate_angle_frame_decoder_unit dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_decimation_count_i(cfg_decimation_count_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .mode_i                (mode_i),
    .data_byte_i           (data_byte_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .status_o              (status_o),
    .roll_rate_o           (roll_rate_o),
    .pitch_rate_o          (pitch_rate_o),
    .yaw_rate_o            (yaw_rate_o),
    .roll_angle_o          (roll_angle_o),
    .pitch_angle_o         (pitch_angle_o),
    .yaw_angle_o           (yaw_angle_o),
    .temperature_centi_o   (temperature_centi_o)
  );

  imu_rate_angle_frame_decoder_checker frame_check (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_i           (cfg_ready_o),
    .cfg_decimation_count_i(cfg_decimation_count_i),
    .in_valid_i            (in_valid_i),
    .in_ready_i            (in_ready_o),
    .mode_i                (mode_i),
    .data_byte_i           (data_byte_i),
    .out_valid_i           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .status_i              (status_o),
    .roll_rate_i           (roll_rate_o),
    .pitch_rate_i          (pitch_rate_o),
    .yaw_rate_i            (yaw_rate_o),
    .roll_angle_i          (roll_angle_o),
    .pitch_angle_i         (pitch_angle_o),
    .yaw_angle_i           (yaw_angle_o),
    .temperature_centi_i   (temperature_centi_o),
    .fail_count_o          (fail_count),
    .pending_o             (pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= 27);
  end

  task automatic send_beat(input mode_e m, input logic [7:0] b);
    if (!quiet && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!quiet && $urandom_range(99) < 27);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  // bytes at store slots: headers, rate words, angle and temperature words, filler
  task automatic send_frame(input int unsigned len, input int unsigned fault);
    int unsigned slot;
    int unsigned h;
    logic [7:0]  hdr;
    logic [7:0]  b;
    logic [15:0] w;
    for (int unsigned p = 0; p < len; p++) begin
      slot = p % StoreDepthDefault;
      b    = 8'($urandom);
      if (slot >= RatePos + 2 && slot < RatePos + 8) begin
        w = frame_words[(slot - RatePos - 2) / 2];
        b = ((slot - RatePos) % 2 == 0) ? w[7:0] : w[15:8];
      end else if (slot >= AnglePos + 2 && slot <= TempPos + 1) begin
        w = frame_words[3 + (slot - AnglePos - 2) / 2];
        b = ((slot - AnglePos) % 2 == 0) ? w[7:0] : w[15:8];
      end
      h   = HdrIntact;
      hdr = '0;
      case (slot)
        RatePos:      begin h = 0; hdr = HdrSync; end
        RatePos + 1:  begin h = 1; hdr = HdrRate; end
        AnglePos:     begin h = 2; hdr = HdrSync; end
        AnglePos + 1: begin h = 3; hdr = HdrAngle; end
        default: ;
      endcase
      if (h != HdrIntact) b = (h == fault) ? hdr ^ 8'($urandom_range(1, 255)) : hdr;
      send_beat(ModeByte, b);
    end
    send_beat(ModeIdle, 8'($urandom));
  endtask

  // hold input, let all results drain, then cover the pipeline depth
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_decimation(input logic [DecimWidth-1:0] v);
    settle();
    cfg_valid_i            <= 1'b1;
    cfg_decimation_count_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned phase;
    int unsigned frames;
    int unsigned pick;
    logic [DecimWidth-1:0] dec;
    phase = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store at reset decimation: error frame
    repeat (3) send_beat(ModeIdle, 8'h00);

    load_decimation(4'd1);
    frame_words = '{16'h8000, 16'h7fff, 16'hffff, 16'h7fff, 16'h8000, 16'h0001, 16'h7fff};
    send_frame(32, HdrIntact);
    frame_words = '{16'h0000, 16'h0001, 16'hfffe, 16'hffff, 16'h0000, 16'h7fff, 16'h8000};
    send_frame(33, HdrIntact);
    send_frame(34, HdrIntact);
    frame_words = '{16'h1234, 16'hedcb, 16'h0002, 16'hffff, 16'h0002, 16'hfffe, 16'hffff};
    send_frame(5, HdrIntact);
    for (int unsigned h = 0; h < 4; h++) send_frame(32, h);
    send_frame(24, HdrIntact);
    send_frame(66, HdrIntact);
    send_frame(64, HdrIntact);
    send_frame(98, HdrIntact);

    // lowering the decimation below the running idle count
    load_decimation(4'd15);
    repeat (4) send_beat(ModeIdle, 8'hff);
    load_decimation(4'd2);
    send_beat(ModeIdle, 8'h00);
    send_frame(32, HdrIntact);

    load_decimation(4'd0);
    send_frame(32, HdrIntact);
    send_frame(0, HdrIntact);

    while (beats_sent < 1400) begin
      phase++;
      quiet  = (phase == 1);
      dec    = (phase % 6 == 0) ? 4'($urandom_range(3, 8)) : 4'($urandom_range(2));
      load_decimation(dec);
      frames = dec + $urandom_range(2, 8);
      for (int unsigned f = 0; f < frames; f++) begin
        foreach (frame_words[j]) begin
          pick = $urandom_range(7);
          frame_words[j] = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7fff : 16'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_frame($urandom_range(31, 33),
                     ($urandom_range(11) < 2) ? $urandom_range(3) : HdrIntact);
        end else if (pick < 80) begin
          send_frame($urandom_range(64, 100), HdrIntact);
        end else if (pick < 90) begin
          send_frame($urandom_range(10), HdrIntact);
        end else begin
          repeat ($urandom_range(70)) send_beat(ModeByte, 8'($urandom));
          send_beat(ModeIdle, 8'($urandom));
        end
      end
    end
    quiet = 1'b0;

    settle();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
